// ===== hw/rtl/psi_pkg.sv =====
`default_nettype none
package psi_pkg;
	localparam int MAX_POINTS = 16;

	typedef struct packed {
		logic        mode;
		logic [3:0]  point_index;
		logic [31:0] point_time;
		logic [31:0] point_temp;
		logic [31:0] elapsed_time;
	} in_t;

	typedef struct packed {
		logic [31:0] target_temp;
		logic        status;
	} out_t;

	localparam logic [1:0] REG_MAX_TARGET   = 2'd0;
	localparam logic [1:0] REG_MAX_DURATION = 2'd1;
	localparam logic [1:0] REG_POINTS       = 2'd2;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// divider handshake
	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [32:0] divisor;
	} div_req_t;
endpackage
`default_nettype wire

// ===== hw/rtl/psi_div.sv =====
`default_nettype none
module psi_div
	import psi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire div_req_t    req,
	output logic             busy,
	output logic             done,
	output logic [63:0]      quotient
);
	logic [6:0]  cnt_q;
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [32:0] dvs_q;
	logic [33:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, dvs_q};
	assign busy = (cnt_q != 7'd0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= (cnt_q == 7'd1);
			if (req.start) cnt_q <= 7'd64;
			else if (cnt_q != 7'd0) cnt_q <= cnt_q - 7'd1;
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != 7'd0) begin
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/profile_setpoint_interpolator_top.sv =====
// A point write, or a query with a bad point count, answers in the cycle after accept.
// A query walks the table point by point (memory read, then check), then, unless a
// point fails a check or the time lies past the last point, does one 32x32 multiply
// and a 64-step restoring divide.
// One request at a time; the next is taken the cycle after the result is accepted.
// Reset (arst_n low) clears the control and config registers and empties the whole table (valid bits per slot).
`default_nettype none
module profile_setpoint_interpolator_top
	import psi_pkg::*;
#(
	parameter logic [31:0] DEFAULT_MAX_TARGET = 32'd250000,
	parameter logic [31:0] DEFAULT_MAX_DURATION = 32'd1800000
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_t         in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_t             out_data,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam int SLOTS = (MAX_POINTS < 16) ? MAX_POINTS : 16;
	localparam int AW = 4;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_READ = 6'b000010,
		S_SCAN = 6'b000100,
		S_MUL  = 6'b001000,
		S_DIV  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	logic [31:0] tlim_cfg_q, dlim_cfg_q;
	logic [7:0]  npts_q;
	logic [63:0] mem_q [SLOTS];
	logic [15:0] vld_q;
	logic [63:0] rd_s1;
	logic        rd_vld_s1;
	logic [AW:0] idx_q;
	logic [31:0] elapsed_q, prev_time_q, prev_temp_q;
	logic        found_q, bad_q, first_q;
	logic [31:0] res_q;
	logic [31:0] mag_q, dt_q, off_q;
	logic        neg_q;
	div_req_t    dreq;
	logic        dbusy, ddone;
	logic [63:0] dquo;

	logic [31:0] tlim, dlim, cur_time, cur_temp;
	logic        slot_ok;
	logic [7:0]  last_idx;

	assign tlim = ($signed(tlim_cfg_q) > 0) ? tlim_cfg_q : DEFAULT_MAX_TARGET;
	assign dlim = (dlim_cfg_q != 0) ? dlim_cfg_q : DEFAULT_MAX_DURATION;
	assign cur_time = rd_vld_s1 ? rd_s1[63:32] : 32'd0;
	assign cur_temp = rd_vld_s1 ? rd_s1[31:0] : 32'd0;
	assign last_idx = npts_q - 8'd1;
	assign in_ready = (state_q == S_IDLE) && !out_valid;
	assign slot_ok = (32'(in_data.point_index) < 32'(MAX_POINTS));

	psi_div u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq),
		.busy(dbusy), .done(ddone), .quotient(dquo)
	);

	always_comb begin
		dreq.start = (state_q == S_MUL);
		dreq.dividend = 64'(mag_q) * 64'(off_q);
		dreq.divisor = {1'b0, dt_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlim_cfg_q <= '0;
			dlim_cfg_q <= '0;
			npts_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_TARGET:   tlim_cfg_q <= cfg_data;
				REG_MAX_DURATION: dlim_cfg_q <= cfg_data;
				REG_POINTS:       npts_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// table memory; unwritten slots read as zero via valid bits
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && in_ready && in_data.mode == MODE_WRITE
				&& slot_ok)
			mem_q[in_data.point_index[AW-1:0]] <= {in_data.point_time, in_data.point_temp};
		rd_s1 <= mem_q[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (state_q == S_IDLE && in_valid && in_ready && in_data.mode == MODE_WRITE
					&& slot_ok)
				vld_q[in_data.point_index] <= 1'b1;
			rd_vld_s1 <= vld_q[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					if (in_data.mode == MODE_WRITE) out_valid <= 1'b1;
					else if (npts_q < 8'd2 || 32'(npts_q) > 32'(MAX_POINTS))
						out_valid <= 1'b1;
					else state_q <= S_READ;
				end
				S_READ: state_q <= S_SCAN;
				S_SCAN: begin
					if (bad_q || (cur_time > dlim) || ($signed(cur_temp) > $signed(tlim))
							|| (first_q && cur_time != 0)
							|| (!first_q && cur_time <= prev_time_q)) begin
						state_q <= S_IDLE;
						out_valid <= 1'b1;
					end else if ({3'd0, idx_q} == last_idx) begin
						if (found_q || elapsed_q <= cur_time) state_q <= S_MUL;
						else begin
							state_q <= S_IDLE;
							out_valid <= 1'b1;
						end
					end else state_q <= S_READ;
				end
				S_MUL: state_q <= S_DIV;
				S_DIV: if (ddone) begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					state_q <= S_IDLE;
					out_valid <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath; found/bracket recorded while checking every point
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (in_valid && in_ready) begin
				idx_q <= '0;
				first_q <= 1'b1;
				found_q <= 1'b0;
				bad_q <= 1'b0;
				elapsed_q <= in_data.elapsed_time;
				out_data.target_temp <= '0;
				out_data.status <= (in_data.mode == MODE_QUERY);
			end
			S_SCAN: begin
				prev_time_q <= cur_time;
				prev_temp_q <= cur_temp;
				first_q <= 1'b0;
				idx_q <= idx_q + 1'b1;
				if (!found_q) begin
					if (first_q) begin
						if (elapsed_q <= cur_time) begin
							found_q <= 1'b1;
							res_q <= cur_temp;
							mag_q <= '0;
							dt_q <= 32'd1;
							off_q <= '0;
							neg_q <= 1'b0;
						end
					end else if (elapsed_q <= cur_time) begin
						found_q <= 1'b1;
						res_q <= prev_temp_q;
						neg_q <= $signed(cur_temp) < $signed(prev_temp_q);
						mag_q <= ($signed(cur_temp) < $signed(prev_temp_q))
							? prev_temp_q - cur_temp : cur_temp - prev_temp_q;
						dt_q <= cur_time - prev_time_q;
						off_q <= elapsed_q - prev_time_q;
					end
				end
				// hold last temperature past the end
				if ({3'd0, idx_q} == last_idx && !found_q && !(elapsed_q <= cur_time))
					out_data.target_temp <= cur_temp;
				if ({3'd0, idx_q} == last_idx && !found_q && (elapsed_q <= cur_time)
						&& first_q)
					out_data.target_temp <= cur_temp;
				out_data.status <= 1'b1;
				if (!(bad_q || (cur_time > dlim) || ($signed(cur_temp) > $signed(tlim))
						|| (first_q && cur_time != 0)
						|| (!first_q && cur_time <= prev_time_q))
						&& {3'd0, idx_q} == last_idx)
					out_data.status <= 1'b0;
				if (bad_q || (cur_time > dlim) || ($signed(cur_temp) > $signed(tlim))
						|| (first_q && cur_time != 0)
						|| (!first_q && cur_time <= prev_time_q))
					out_data.target_temp <= '0;
			end
			S_OUT: out_data.target_temp <= neg_q ? res_q - dquo[31:0] : res_q + dquo[31:0];
			default: ;
		endcase
	end

	logic unused;
	assign unused = dbusy;
endmodule
`default_nettype wire

// ===== test/tb_profile_setpoint_interpolator_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_profile_setpoint_interpolator_top;
	import psi_pkg::*;

	localparam int NUM_SLOTS = 16;
	localparam int DEF_TARGET = 250000;
	localparam logic [31:0] DEF_DURATION = 32'd1800000;
	localparam int DRAIN_CYCLES = 120;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_MAX_TARGET;
	logic [31:0] cfg_data = '0;

	always #1 clk = ~clk;

	profile_setpoint_interpolator_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [31:0] pt_times [NUM_SLOTS];
	logic signed [31:0] pt_temps [NUM_SLOTS];
	logic signed [31:0] lim_target;
	logic [31:0] lim_duration;
	logic [7:0] num_points;

	out_t setpoint_q[$];
	int errors = 0;
	int sent = 0;
	int queries = 0;
	int invalids = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;
	int quiet_cycles = 0;

	task automatic report(input string what, input out_t got, input out_t want);
		$display("ERROR %0t %s: got temp %0d status %0d, want temp %0d status %0d",
			$time, what, $signed(got.target_temp), got.status,
			$signed(want.target_temp), want.status);
		errors++;
	endtask

	function automatic bit profile_valid();
		logic signed [31:0] tl;
		logic [31:0] dl;
		tl = (lim_target > 0) ? lim_target : DEF_TARGET;
		dl = (lim_duration != 0) ? lim_duration : DEF_DURATION;
		if (num_points < 2 || num_points > NUM_SLOTS) return 0;
		if (pt_times[0] != 0) return 0;
		for (int i = 0; i < num_points; i++) begin
			if (pt_temps[i] > tl || pt_times[i] > dl) return 0;
			if (i > 0 && pt_times[i] <= pt_times[i-1]) return 0;
		end
		return 1;
	endfunction

	function automatic logic signed [31:0] interp_setpoint(input logic [31:0] t);
		logic signed [63:0] ta, tb, r;
		logic [63:0] span, offs, mag, q;
		if (t <= pt_times[0]) return pt_temps[0];
		for (int i = 1; i < num_points; i++) begin
			if (t <= pt_times[i]) begin
				ta = pt_temps[i-1];
				tb = pt_temps[i];
				span = {32'd0, pt_times[i]} - {32'd0, pt_times[i-1]};
				offs = {32'd0, t} - {32'd0, pt_times[i-1]};
				mag = (tb < ta) ? ta - tb : tb - ta;
				q = (mag * offs) / span;
				r = (tb < ta) ? ta - $signed(q) : ta + $signed(q);
				return r[31:0];
			end
		end
		return pt_temps[num_points-1];
	endfunction

	function automatic out_t predict_setpoint(input in_t req);
		out_t res;
		res = '0;
		if (req.mode == MODE_WRITE) begin
			pt_times[req.point_index] = req.point_time;
			pt_temps[req.point_index] = req.point_temp;
		end else if (profile_valid()) begin
			res.target_temp = interp_setpoint(req.elapsed_time);
		end else begin
			res.status = 1'b1;
		end
		return res;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		in_valid <= 1'b0;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MAX_TARGET: lim_target = val;
			REG_MAX_DURATION: lim_duration = val;
			default: num_points = val[7:0];
		endcase
	endtask

	// forced expectation: typed-in value checked against the predictor's result
	task automatic send_request(input in_t req, input bit has_fixed, input out_t fixed);
		out_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
		want = predict_setpoint(req);
		if (has_fixed && want != fixed) report("directed row", fixed, want);
		setpoint_q.push_back(want);
		sent++;
		if (req.mode == MODE_QUERY) queries++;
		if (want.status) invalids++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (setpoint_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic in_t write_item(input int idx, input logic [31:0] t, input logic [31:0] v);
		in_t r;
		r = '0;
		r.mode = MODE_WRITE;
		r.point_index = idx;
		r.point_time = t;
		r.point_temp = v;
		return r;
	endfunction

	function automatic in_t query_item(input logic [31:0] t);
		in_t r;
		r = '0;
		r.mode = MODE_QUERY;
		r.elapsed_time = t;
		r.point_index = $urandom;
		r.point_time = $urandom;
		r.point_temp = $urandom;
		return r;
	endfunction

	// load a valid profile of n points with random content
	task automatic load_profile(input int n, input logic [31:0] dlim, input int tlim);
		logic [31:0] t;
		logic [31:0] stepmax;
		t = 0;
		stepmax = dlim / n;
		if (stepmax == 0) stepmax = 1;
		for (int i = 0; i < n; i++) begin
			send_request(write_item(i, t, tlim - $urandom_range(400000)), 0, '0);
			t = t + $urandom_range(stepmax, 1);
		end
	endtask

	// receiver
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (setpoint_q.size() == 0) begin
				report("unexpected result", out_data, '0);
			end else if (out_data != setpoint_q[0]) begin
				report("result mismatch", out_data, setpoint_q[0]);
				void'(setpoint_q.pop_front());
			end else begin
				void'(setpoint_q.pop_front());
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n || hold_off > 0)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", quiet_cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	typedef struct {
		in_t req;
		bit has_fixed;
		out_t fixed;
	} row_t;

	row_t rows[$];
	out_t zero_ok = '{target_temp: 32'd0, status: 1'b0};
	out_t bad = '{target_temp: 32'd0, status: 1'b1};

	initial begin
		int phase;
		int n;
		logic [31:0] dl;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			pt_times[i] = '0;
			pt_temps[i] = '0;
		end
		lim_target = 0;
		lim_duration = 0;
		num_points = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: after reset the profile is invalid
		rows.push_back('{query_item(32'd0), 1, bad});
		rows.push_back('{query_item(32'hFFFF_FFFF), 1, bad});
		foreach (rows[i]) send_request(rows[i].req, rows[i].has_fixed, rows[i].fixed);
		rows.delete();
		drain();

		write_reg(REG_POINTS, 8'd3);
		rows.push_back('{write_item(0, 32'd0, 32'sd20000), 1, zero_ok});
		rows.push_back('{write_item(1, 32'd1000, 32'sd200000), 1, zero_ok});
		rows.push_back('{write_item(2, 32'd1800000, -32'sd1000), 1, zero_ok});
		rows.push_back('{query_item(32'd0), 1, '{32'sd20000, 1'b0}});
		rows.push_back('{query_item(32'd1000), 1, '{32'sd200000, 1'b0}});
		rows.push_back('{query_item(32'hFFFF_FFFF), 1, '{-32'sd1000, 1'b0}});
		rows.push_back('{query_item(32'd333), 0, '0});
		rows.push_back('{query_item(32'd900001), 0, '0});
		// temperature above default limit
		rows.push_back('{write_item(1, 32'd1000, 32'sd250001), 1, zero_ok});
		rows.push_back('{query_item(32'd5), 1, bad});
		rows.push_back('{write_item(1, 32'd1000, 32'sd250000), 1, zero_ok});
		// time beyond default duration
		rows.push_back('{write_item(2, 32'd1800001, 32'sd0), 1, zero_ok});
		rows.push_back('{query_item(32'd5), 1, bad});
		// times not increasing
		rows.push_back('{write_item(2, 32'd1000, 32'sd0), 1, zero_ok});
		rows.push_back('{query_item(32'd5), 1, bad});
		// first time not zero
		rows.push_back('{write_item(2, 32'd5000, 32'sd0), 1, zero_ok});
		rows.push_back('{write_item(0, 32'd1, 32'sd0), 1, zero_ok});
		rows.push_back('{query_item(32'd5), 1, bad});
		rows.push_back('{write_item(0, 32'd0, 32'h8000_0000), 1, zero_ok});
		rows.push_back('{query_item(32'd500), 0, '0});
		rows.push_back('{write_item(15, 32'hFFFF_FFFF, 32'h7FFF_FFFF), 1, zero_ok});
		foreach (rows[i]) send_request(rows[i].req, rows[i].has_fixed, rows[i].fixed);
		rows.delete();
		drain();

		// register extremes: wide span with extreme temperatures
		write_reg(REG_MAX_TARGET, 32'h7FFF_FFFF);
		write_reg(REG_MAX_DURATION, 32'hFFFF_FFFF);
		write_reg(REG_POINTS, 8'd2);
		send_request(write_item(0, 32'd0, 32'h8000_0000), 1, zero_ok);
		send_request(write_item(1, 32'hFFFF_FFFF, 32'h7FFF_FFFF), 1, zero_ok);
		send_request(query_item(32'h7FFF_FFFF), 0, '0);
		send_request(query_item(32'hFFFF_FFFE), 0, '0);
		drain();
		write_reg(REG_POINTS, 8'd16);
		send_request(query_item(32'd1), 0, '0);
		drain();
		write_reg(REG_POINTS, 8'd17);
		send_request(query_item(32'd1), 1, bad);
		drain();
		write_reg(REG_POINTS, 8'd255);
		send_request(query_item(32'd1), 1, bad);
		drain();
		write_reg(REG_POINTS, 8'd1);
		send_request(query_item(32'd1), 1, bad);
		drain();
		write_reg(REG_MAX_TARGET, 32'h8000_0000);
		write_reg(REG_MAX_DURATION, 32'd0);

		// random phases with varying idling and limits
		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 55; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 55; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			drain();
			case (phase % 3)
				0: begin
					write_reg(REG_MAX_TARGET, 32'd0);
					write_reg(REG_MAX_DURATION, 32'd0);
				end
				1: begin
					write_reg(REG_MAX_TARGET, 32'h7FFF_FFFF);
					write_reg(REG_MAX_DURATION, 32'hFFFF_FFFF);
				end
				default: begin
					write_reg(REG_MAX_TARGET, $urandom_range(2000000, 1));
					write_reg(REG_MAX_DURATION, $urandom_range(32'hFFFF_FFFF, 1));
				end
			endcase
			n = $urandom_range(NUM_SLOTS, 2);
			write_reg(REG_POINTS, n);
			dl = (lim_duration != 0) ? lim_duration : DEF_DURATION;
			if (phase == 2) hold_off = 400;
			for (int k = 0; k < 90; k++) begin
				case ($urandom_range(19))
					0: send_request(write_item($urandom, $urandom, $urandom), 0, '0);
					1, 2: begin
						n = $urandom_range(NUM_SLOTS, 2);
						drain();
						write_reg(REG_POINTS, n);
						load_profile(n, dl,
							(lim_target > 0) ? lim_target : DEF_TARGET);
					end
					3: send_request(query_item($urandom), 0, '0);
					default: send_request(query_item($urandom_range(dl)), 0, '0);
				endcase
			end
		end

		drain();
		$display("Covered %0d requests (%0d queries, %0d with an invalid profile),",
			sent, queries, invalids);
		$display("under register extremes, varied idling and one long output hold-off.");
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/psi_pkg.sv
hw/rtl/psi_div.sv
hw/rtl/profile_setpoint_interpolator_top.sv
test/tb_profile_setpoint_interpolator_top.sv
